/* src/assert_macros.svh */
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define CPQM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("cpqm assertion failed");

// clocked assertion that also holds during reset
`define CPQM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("cpqm assertion failed");

`endif

/* src/cpqm_pkg.sv */
// shared types and constants of the cascaded pid quad mixer
// no dependencies
package cpqm_pkg;

    localparam int NUM_LOOPS = 6;
    localparam int NUM_AXES  = 3;
    localparam int LOOP_W    = 3;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 16;
    localparam int GAINS_W   = 48;
    localparam int WORD_W    = 32;

    localparam logic [LOOP_W-1:0] LOOP_FIRST  = 3'd0;
    localparam logic [LOOP_W-1:0] RATE_LOOP0  = 3'd3;
    localparam logic [LOOP_W-1:0] LOOP_LAST   = 3'd5;

    localparam logic [WORD_W-1:0] MOTOR_IDLE = 32'd199999;
    localparam logic [WORD_W-1:0] MOTOR_ARM  = 32'd179999;

    typedef enum logic [2:0] {
        KIND_NEW_DATA = 3'd0,
        KIND_STEP     = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_ARM      = 3'd3,
        KIND_DISARM   = 3'd4,
        KIND_STATUS   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        RES_COMMIT = 2'd0,
        RES_STOP   = 2'd1,
        RES_HALTED = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        GAIN_KP = 2'd0,
        GAIN_KI = 2'd1,
        GAIN_KD = 2'd2
    } gain_sel_t;

    typedef struct packed {
        logic              latch;
        logic              load_e;
        logic              mul;
        gain_sel_t         gsel;
        logic              acc_first;
        logic              acc_add;
        logic              store;
        logic              mix;
        logic              emit_pid;
        logic              emit_fixed;
        res_kind_t         fixed_kind;
        logic [LOOP_W-1:0] loop;
    } dp_cmd_t;

endpackage

/* src/cpqm_if.sv */
// request, result and configuration channels
// depends on cpqm_pkg
interface cpqm_cmd_if;
    import cpqm_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] angle_err_x;
    logic signed [31:0] angle_err_y;
    logic signed [31:0] angle_err_z;
    logic signed [31:0] thrust_in;
    logic signed [31:0] rate_meas_x;
    logic signed [31:0] rate_meas_y;
    logic signed [31:0] rate_meas_z;

    modport source (
        output valid, kind, angle_err_x, angle_err_y, angle_err_z, thrust_in,
               rate_meas_x, rate_meas_y, rate_meas_z,
        input  ready
    );
    modport sink (
        input  valid, kind, angle_err_x, angle_err_y, angle_err_z, thrust_in,
               rate_meas_x, rate_meas_y, rate_meas_z,
        output ready
    );
endinterface

interface cpqm_res_if;
    import cpqm_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] motor_0;
    logic [31:0] motor_1;
    logic [31:0] motor_2;
    logic [31:0] motor_3;

    modport source (
        output valid, result_kind, motor_0, motor_1, motor_2, motor_3,
        input  ready
    );
    modport sink (
        input  valid, result_kind, motor_0, motor_1, motor_2, motor_3,
        output ready
    );
endinterface

interface cpqm_cfg_if;
    import cpqm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAINS_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* src/cpqm_datapath.sv */
// pid datapath: gain registers, loop state, shared multiplier and motor mixer
// depends on cpqm_pkg
module cpqm_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cpqm_pkg::dp_cmd_t                dcmd,
    input  logic                             cfg_we,
    input  logic [cpqm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpqm_pkg::GAINS_W-1:0]     cfg_data,
    input  logic [cpqm_pkg::WORD_W-1:0]      angle_err_x,
    input  logic [cpqm_pkg::WORD_W-1:0]      angle_err_y,
    input  logic [cpqm_pkg::WORD_W-1:0]      angle_err_z,
    input  logic [cpqm_pkg::WORD_W-1:0]      thrust_in,
    input  logic [cpqm_pkg::WORD_W-1:0]      rate_meas_x,
    input  logic [cpqm_pkg::WORD_W-1:0]      rate_meas_y,
    input  logic [cpqm_pkg::WORD_W-1:0]      rate_meas_z,
    output cpqm_pkg::res_kind_t              result_kind,
    output logic [cpqm_pkg::WORD_W-1:0]      motor_0,
    output logic [cpqm_pkg::WORD_W-1:0]      motor_1,
    output logic [cpqm_pkg::WORD_W-1:0]      motor_2,
    output logic [cpqm_pkg::WORD_W-1:0]      motor_3
);
    import cpqm_pkg::*;

    logic [GAINS_W-1:0] gains_reg   [NUM_LOOPS];
    logic [WORD_W-1:0]  integ_reg   [NUM_LOOPS];
    logic [WORD_W-1:0]  prev_reg    [NUM_LOOPS];
    logic [WORD_W-1:0]  pid_out_reg [NUM_LOOPS];
    logic [WORD_W-1:0]  angle_reg   [NUM_AXES];
    logic [WORD_W-1:0]  rate_reg    [NUM_AXES];
    logic [WORD_W-1:0]  thrust_reg;

    logic [WORD_W-1:0]  e_reg;
    logic [WORD_W-1:0]  d_reg;
    logic [WORD_W-1:0]  prod_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  mix_a_reg;
    logic [WORD_W-1:0]  mix_b_reg;
    logic [WORD_W-1:0]  s01_reg;
    logic [WORD_W-1:0]  d01_reg;
    res_kind_t          res_kind_reg;
    logic [WORD_W-1:0]  motor_reg [4];

    logic                     rate_loop;
    logic [AXIS_W-1:0]        axis;
    logic [WORD_W-1:0]        e_next;
    logic [WORD_W-1:0]        integ_next;
    logic [GAINS_W-1:0]       gains_cur;
    logic signed [GAIN_W-1:0] gain_op;
    logic [WORD_W-1:0]        mul_x;
    logic signed [GAIN_W+WORD_W-1:0] mul_full;
    logic [WORD_W-1:0]        fixed_word;

    assign rate_loop  = (dcmd.loop >= RATE_LOOP0);
    assign axis       = rate_loop ? AXIS_W'(dcmd.loop - RATE_LOOP0) : dcmd.loop[AXIS_W-1:0];
    assign e_next     = rate_loop ? (pid_out_reg[{1'b0, axis}] - rate_reg[axis])
                                  : angle_reg[axis];
    assign integ_next = integ_reg[dcmd.loop] + e_next;
    assign gains_cur  = gains_reg[dcmd.loop];

    always_comb
    begin
        case (dcmd.gsel)
            GAIN_KP:
            begin
                gain_op = gains_cur[GAIN_W-1:0];
                mul_x   = e_reg;
            end
            GAIN_KI:
            begin
                gain_op = gains_cur[2*GAIN_W-1:GAIN_W];
                mul_x   = integ_reg[dcmd.loop];
            end
            GAIN_KD:
            begin
                gain_op = gains_cur[3*GAIN_W-1:2*GAIN_W];
                mul_x   = d_reg;
            end
            default:
            begin
                gain_op = '0;
                mul_x   = '0;
            end
        endcase
    end

    assign mul_full   = gain_op * $signed(mul_x);
    assign fixed_word = (dcmd.fixed_kind == RES_COMMIT) ? MOTOR_ARM : '0;

    // loop state, gains and latched inputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOOPS; i++)
            begin
                gains_reg[i] <= '0;
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                angle_reg[i] <= '0;
                rate_reg[i]  <= '0;
            end
            thrust_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_LOOPS)))
                gains_reg[cfg_index] <= cfg_data;
            if (dcmd.latch)
            begin
                angle_reg[0] <= angle_err_x;
                angle_reg[1] <= angle_err_y;
                angle_reg[2] <= angle_err_z;
                rate_reg[0]  <= rate_meas_x;
                rate_reg[1]  <= rate_meas_y;
                rate_reg[2]  <= rate_meas_z;
                thrust_reg   <= thrust_in;
            end
            if (dcmd.load_e)
            begin
                integ_reg[dcmd.loop] <= integ_next;
                prev_reg[dcmd.loop]  <= e_next;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        if (dcmd.load_e)
        begin
            e_reg <= e_next;
            d_reg <= e_next - prev_reg[dcmd.loop];
        end
        if (dcmd.mul)
            prod_reg <= mul_full[WORD_W-1:0];
        if (dcmd.acc_first)
            acc_reg <= prod_reg;
        else if (dcmd.acc_add)
            acc_reg <= acc_reg + prod_reg;
        if (dcmd.store)
            pid_out_reg[dcmd.loop] <= acc_reg + prod_reg;
        if (dcmd.mix)
        begin
            mix_a_reg <= MOTOR_IDLE + thrust_reg + pid_out_reg[5];
            mix_b_reg <= MOTOR_IDLE + thrust_reg - pid_out_reg[5];
            s01_reg   <= pid_out_reg[3] + pid_out_reg[4];
            d01_reg   <= pid_out_reg[3] - pid_out_reg[4];
        end
        if (dcmd.emit_pid)
        begin
            res_kind_reg <= RES_COMMIT;
            motor_reg[0] <= mix_a_reg + s01_reg;
            motor_reg[1] <= mix_b_reg - d01_reg;
            motor_reg[2] <= mix_b_reg + d01_reg;
            motor_reg[3] <= mix_a_reg - s01_reg;
        end
        else if (dcmd.emit_fixed)
        begin
            res_kind_reg <= dcmd.fixed_kind;
            for (int i = 0; i < 4; i++)
                motor_reg[i] <= fixed_word;
        end
    end

    assign result_kind = res_kind_reg;
    assign motor_0     = motor_reg[0];
    assign motor_1     = motor_reg[1];
    assign motor_2     = motor_reg[2];
    assign motor_3     = motor_reg[3];

endmodule

/* src/cpqm_ctrl.sv */
// controller: request decode, pid step sequencer, halt flag and result valid
// depends on cpqm_pkg
module cpqm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [2:0]           cmd_kind,
    output logic                 cmd_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    output cpqm_pkg::dp_cmd_t    dcmd
);
    import cpqm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_M0   = 8'b0000_0100,
        S_M1   = 8'b0000_1000,
        S_M2   = 8'b0001_0000,
        S_M3   = 8'b0010_0000,
        S_MIX1 = 8'b0100_0000,
        S_MIX2 = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [LOOP_W-1:0] loop_reg, loop_next;
    logic              halted_reg, halted_next;
    logic              res_valid_reg, res_valid_next;
    logic              accept;

    assign cmd_ready = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        loop_next   = loop_reg;
        halted_next = halted_reg;
        dcmd        = '0;
        dcmd.gsel       = GAIN_KP;
        dcmd.fixed_kind = RES_COMMIT;
        dcmd.loop       = loop_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !halted_reg)
                begin
                    case (kind_t'(cmd_kind))
                        KIND_NEW_DATA:
                            dcmd.latch = 1'b1;
                        KIND_STEP:
                        begin
                            loop_next  = LOOP_FIRST;
                            state_next = S_LOAD;
                        end
                        KIND_ARM:
                            dcmd.latch = 1'b0;
                        KIND_DISARM:
                        begin
                            dcmd.emit_fixed = 1'b1;
                            dcmd.fixed_kind = RES_COMMIT;
                        end
                        KIND_STATUS:
                        begin
                            halted_next     = 1'b1;
                            dcmd.emit_fixed = 1'b1;
                            dcmd.fixed_kind = RES_HALTED;
                        end
                        default:
                        begin
                            dcmd.emit_fixed = 1'b1;
                            dcmd.fixed_kind = RES_STOP;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                dcmd.load_e = 1'b1;
                state_next  = S_M0;
            end
            S_M0:
            begin
                dcmd.mul   = 1'b1;
                dcmd.gsel  = GAIN_KP;
                state_next = S_M1;
            end
            S_M1:
            begin
                dcmd.mul       = 1'b1;
                dcmd.gsel      = GAIN_KI;
                dcmd.acc_first = 1'b1;
                state_next     = S_M2;
            end
            S_M2:
            begin
                dcmd.mul     = 1'b1;
                dcmd.gsel    = GAIN_KD;
                dcmd.acc_add = 1'b1;
                state_next   = S_M3;
            end
            S_M3:
            begin
                dcmd.store = 1'b1;
                if (loop_reg == LOOP_LAST)
                    state_next = S_MIX1;
                else
                begin
                    loop_next  = loop_reg + LOOP_W'(1);
                    state_next = S_LOAD;
                end
            end
            S_MIX1:
            begin
                dcmd.mix   = 1'b1;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                dcmd.emit_pid = 1'b1;
                state_next    = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (dcmd.emit_pid || dcmd.emit_fixed)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loop_reg      <= LOOP_FIRST;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loop_reg      <= loop_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* src/cascaded_pid_quad_mixer_core.sv */
// step request: six pid loops, each through the load, multiply and store states on one
// shared multiplier, then the mixer states; no new request is taken while a step is running
// disarm, status and stop requests: result in the next cycle; waiting results stall requests
// asynchronous active-low reset clears gains, integrators, errors and the halt flag
// gain writes are taken in every cycle
// depends on cpqm_pkg, cpqm_if, cpqm_ctrl and cpqm_datapath
module cascaded_pid_quad_mixer_core (
    input  logic       clk,
    input  logic       rst_n,
    cpqm_cmd_if.sink   cmd,
    cpqm_res_if.source res,
    cpqm_cfg_if.sink   cfg
);
    import cpqm_pkg::*;

    dp_cmd_t   dcmd;
    res_kind_t result_kind;

    assign cfg.ready = 1'b1;

    cpqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_kind  (cmd.kind),
        .cmd_ready (cmd.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .dcmd      (dcmd)
    );

    cpqm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dcmd        (dcmd),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .angle_err_x (cmd.angle_err_x),
        .angle_err_y (cmd.angle_err_y),
        .angle_err_z (cmd.angle_err_z),
        .thrust_in   (cmd.thrust_in),
        .rate_meas_x (cmd.rate_meas_x),
        .rate_meas_y (cmd.rate_meas_y),
        .rate_meas_z (cmd.rate_meas_z),
        .result_kind (result_kind),
        .motor_0     (res.motor_0),
        .motor_1     (res.motor_1),
        .motor_2     (res.motor_2),
        .motor_3     (res.motor_3)
    );

    assign res.result_kind = result_kind;

endmodule

/* src/cpqm_checker.sv */
// port-level checker for the cascaded pid quad mixer core, bound to the top level
// depends on cpqm_pkg and assert_macros.svh
`include "assert_macros.svh"

module cpqm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [2:0]  cmd_kind,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  result_kind,
    input logic [31:0] motor_0,
    input logic [31:0] motor_1,
    input logic [31:0] motor_2,
    input logic [31:0] motor_3
);
    import cpqm_pkg::*;

    logic halted_seen_reg;
    logic step_req;
    logic no_motor_words;
    logic motors_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            halted_seen_reg <= 1'b0;
        else if (res_valid && res_ready && (result_kind == RES_HALTED))
            halted_seen_reg <= 1'b1;
    end

    assign step_req = cmd_valid && cmd_ready && (cmd_kind == KIND_STEP);
    assign no_motor_words = (result_kind == RES_STOP) || (result_kind == RES_HALTED);
    assign motors_zero = (motor_0 == '0) && (motor_1 == '0) && (motor_2 == '0)
                         && (motor_3 == '0);

    `CPQM_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid)
    `CPQM_ASSERT(a_halt_silent, clk, rst_n, halted_seen_reg |-> !res_valid)
    `CPQM_ASSERT(a_step_not_immediate, clk, rst_n, step_req |=> !res_valid)
    `CPQM_ASSERT(a_stop_zero_words, clk, rst_n, res_valid && no_motor_words |-> motors_zero)
    `CPQM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !res_valid)

endmodule

bind cascaded_pid_quad_mixer_core cpqm_checker u_cpqm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_kind    (cmd.kind),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .result_kind (res.result_kind),
    .motor_0     (res.motor_0),
    .motor_1     (res.motor_1),
    .motor_2     (res.motor_2),
    .motor_3     (res.motor_3)
);

/* bench/cpqm_bench_pkg.sv */
`timescale 1ns / 100ps
// request and result types plus the motor word tracker for the quad mixer bench
// depends on cpqm_pkg
package cpqm_bench_pkg;
    import cpqm_pkg::*;

    localparam logic [2:0] KIND_UNEXPECTED_LO = 3'd6;
    localparam logic [2:0] KIND_UNEXPECTED_HI = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_ANGLE_X = 3'd0,
        REG_GAINS_ANGLE_Y = 3'd1,
        REG_GAINS_ANGLE_Z = 3'd2,
        REG_GAINS_RATE_X  = 3'd3,
        REG_GAINS_RATE_Y  = 3'd4,
        REG_GAINS_RATE_Z  = 3'd5
    } gain_reg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] thrust;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } cmd_req_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [31:0] m0;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] m3;
    } motor_result_t;

    class motor_word_tracker;
        bit [GAINS_W-1:0] gains [NUM_LOOPS];
        bit [31:0] integ [NUM_LOOPS];
        bit [31:0] prev_err [NUM_LOOPS];
        bit [31:0] angle_err [NUM_AXES];
        bit [31:0] rate_meas [NUM_AXES];
        bit [31:0] thrust;
        bit armed;
        bit halted;
        motor_result_t expected_motor_words [$];
        int errors;
        int requests;
        int checked;
        int gain_writes;

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] value);
            gain_writes++;
            if (idx < NUM_LOOPS)
                gains[idx] = value;
        endfunction

        function bit [31:0] gain_of(int loop, gain_sel_t slot);
            bit [GAIN_W-1:0] g;
            g = gains[loop][GAIN_W*slot +: GAIN_W];
            return {{16{g[GAIN_W-1]}}, g};
        endfunction

        function bit [31:0] run_loop(int loop, bit [31:0] e);
            bit [31:0] d;
            bit [31:0] r;
            integ[loop] = integ[loop] + e;
            d = e - prev_err[loop];
            r = gain_of(loop, GAIN_KP) * e + gain_of(loop, GAIN_KI) * integ[loop]
                + gain_of(loop, GAIN_KD) * d;
            prev_err[loop] = e;
            return r;
        endfunction

        function void note_request(cmd_req_t r);
            bit [31:0] tgt [NUM_AXES];
            bit [31:0] c [NUM_AXES];
            bit [31:0] base;
            motor_result_t m;
            requests++;
            if (halted)
                return;
            m = '0;
            case (r.kind)
                KIND_NEW_DATA:
                begin
                    angle_err[0] = r.angle_x;
                    angle_err[1] = r.angle_y;
                    angle_err[2] = r.angle_z;
                    rate_meas[0] = r.rate_x;
                    rate_meas[1] = r.rate_y;
                    rate_meas[2] = r.rate_z;
                    thrust = r.thrust;
                    return;
                end
                KIND_STEP:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                        tgt[i] = run_loop(i, angle_err[i]);
                    for (int i = 0; i < NUM_AXES; i++)
                        c[i] = run_loop(RATE_LOOP0 + i, tgt[i] - rate_meas[i]);
                    base = MOTOR_IDLE + thrust;
                    m.kind = RES_COMMIT;
                    m.m0 = base + c[0] + c[1] + c[2];
                    m.m1 = base - c[0] + c[1] - c[2];
                    m.m2 = base + c[0] - c[1] - c[2];
                    m.m3 = base - c[0] - c[1] + c[2];
                end
                KIND_ARM:
                begin
                    armed = 1'b1;
                    return;
                end
                KIND_DISARM:
                begin
                    armed = 1'b0;
                    m.kind = RES_COMMIT;
                    m.m0 = MOTOR_ARM;
                    m.m1 = MOTOR_ARM;
                    m.m2 = MOTOR_ARM;
                    m.m3 = MOTOR_ARM;
                end
                KIND_STATUS:
                begin
                    halted = 1'b1;
                    m.kind = RES_HALTED;
                end
                default:
                    m.kind = RES_STOP;
            endcase
            expected_motor_words.push_back(m);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s expected %h actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(motor_result_t got);
            motor_result_t want;
            checked++;
            if (expected_motor_words.size() == 0)
            begin
                $error("result_kind %0d arrived with no request pending", got.kind);
                errors++;
                return;
            end
            want = expected_motor_words.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("motor_0", want.m0, got.m0);
            compare_field("motor_1", want.m1, got.m1);
            compare_field("motor_2", want.m2, got.m2);
            compare_field("motor_3", want.m3, got.m3);
        endfunction

        function int pending();
            return expected_motor_words.size();
        endfunction

        function void report_leftover();
            if (expected_motor_words.size() != 0)
            begin
                $error("%0d results never arrived", expected_motor_words.size());
                errors += expected_motor_words.size();
            end
        endfunction
    endclass

endpackage

/* bench/tb_cascaded_pid_quad_mixer_core.sv */
`timescale 1ns / 100ps
// top-level bench for cascaded_pid_quad_mixer_core: directed and random requests,
// gain settings per phase, random stalls on both channels, results checked in order
// depends on cpqm_pkg, cpqm_if, the core and cpqm_bench_pkg
module tb_cascaded_pid_quad_mixer_core;
    import cpqm_pkg::*;
    import cpqm_bench_pkg::*;

    localparam int IDLE_SETTLE = 40;
    localparam int LONG_STALL  = 300;
    localparam int PHASE_ITEMS = 64;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum {GS_SMALL, GS_RANDOM, GS_MAX, GS_MIN, GS_ONES, GS_ZERO} gain_style_t;
    typedef logic [GAINS_W-1:0] gain_set_t [NUM_LOOPS];

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   long_stall_req;

    motor_word_tracker tracker = new();

    cpqm_cmd_if cmd ();
    cpqm_res_if res ();
    cpqm_cfg_if cfg ();

    cascaded_pid_quad_mixer_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                tracker.check_result({res.result_kind, res.motor_0, res.motor_1,
                                      res.motor_2, res.motor_3});
            if (cmd.valid && cmd.ready)
                tracker.note_request({cmd.kind, cmd.angle_err_x, cmd.angle_err_y,
                                      cmd.angle_err_z, cmd.thrust_in, cmd.rate_meas_x,
                                      cmd.rate_meas_y, cmd.rate_meas_z});
            if (cfg.valid && cfg.ready)
                tracker.set_gain(cfg.index, cfg.data);
        end
    end

    // result side back-pressure
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                res.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                res.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                res.ready <= 1'b1;
            end
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4, 5: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_req_t fresh(logic [2:0] k);
        cmd_req_t r;
        r.kind    = k;
        r.angle_x = any_word();
        r.angle_y = any_word();
        r.angle_z = any_word();
        r.thrust  = any_word();
        r.rate_x  = any_word();
        r.rate_y  = any_word();
        r.rate_z  = any_word();
        return r;
    endfunction

    function automatic cmd_req_t uniform_data(logic [31:0] w);
        return {KIND_NEW_DATA, w, w, w, w, w, w, w};
    endfunction

    function automatic gain_set_t make_gains(gain_style_t s);
        gain_set_t g;
        logic [GAIN_W-1:0] k [3];
        for (int i = 0; i < NUM_LOOPS; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                case (s)
                    GS_SMALL:  k[j] = GAIN_W'($urandom_range(0, 16) - 8);
                    GS_RANDOM: k[j] = GAIN_W'($urandom);
                    GS_MAX:    k[j] = 16'h7FFF;
                    GS_MIN:    k[j] = 16'h8000;
                    GS_ONES:   k[j] = 16'hFFFF;
                    default:   k[j] = '0;
                endcase
            end
            g[i] = {k[GAIN_KD], k[GAIN_KI], k[GAIN_KP]};
        end
        return g;
    endfunction

    task automatic send_item(input cmd_req_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.kind        <= r.kind;
        cmd.angle_err_x <= r.angle_x;
        cmd.angle_err_y <= r.angle_y;
        cmd.angle_err_z <= r.angle_z;
        cmd.thrust_in   <= r.thrust;
        cmd.rate_meas_x <= r.rate_x;
        cmd.rate_meas_y <= r.rate_y;
        cmd.rate_meas_z <= r.rate_z;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_gains(input gain_set_t g);
        for (int i = 0; i < NUM_LOOPS; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= gain_reg_t'(i);
            cfg.data  <= g[i];
            @(posedge clk);
            while (!cfg.ready) @(posedge clk);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int n);
        int sent;
        int steps;
        logic [2:0] k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // new data followed by one or two steps
                steps = $urandom_range(1, 2);
                send_item(fresh(KIND_NEW_DATA));
                repeat (steps) send_item(fresh(KIND_STEP));
                sent += 1 + steps;
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0: k = KIND_NEW_DATA;
                    1: k = KIND_STEP;
                    2: k = KIND_STOP;
                    3: k = KIND_ARM;
                    4: k = KIND_DISARM;
                    5: k = KIND_UNEXPECTED_LO;
                    default: k = KIND_UNEXPECTED_HI;
                endcase
                send_item(fresh(k));
                sent++;
            end
        end
    endtask

    initial
    begin
        gain_style_t plan [6];
        plan = '{GS_RANDOM, GS_MAX, GS_MIN, GS_ONES, GS_ZERO, GS_SMALL};
        rst_n           <= 1'b0;
        cmd.valid       <= 1'b0;
        cmd.kind        <= KIND_NEW_DATA;
        cmd.angle_err_x <= '0;
        cmd.angle_err_y <= '0;
        cmd.angle_err_z <= '0;
        cmd.thrust_in   <= '0;
        cmd.rate_meas_x <= '0;
        cmd.rate_meas_y <= '0;
        cmd.rate_meas_z <= '0;
        cfg.valid       <= 1'b0;
        cfg.index       <= REG_GAINS_ANGLE_X;
        cfg.data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains, fixed-word requests
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_STOP));
        send_item(fresh(KIND_UNEXPECTED_LO));
        send_item(fresh(KIND_UNEXPECTED_HI));
        send_item(fresh(KIND_ARM));
        send_item(fresh(KIND_DISARM));
        send_item(fresh(KIND_DISARM));
        drain();
        set_gains(make_gains(GS_SMALL));

        // field extremes, repeated steps grow the integrators
        send_item(uniform_data(32'h7FFF_FFFF));
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_STEP));
        send_item(uniform_data(32'h8000_0000));
        send_item(fresh(KIND_STEP));
        send_item(uniform_data(32'h0));
        send_item(fresh(KIND_STEP));
        send_item(uniform_data(32'hFFFF_FFFF));
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_ARM));
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_NEW_DATA));
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_NEW_DATA));
        send_item(fresh(KIND_NEW_DATA));
        send_item(fresh(KIND_STEP));

        foreach (plan[p])
        begin
            drain();
            set_gains(make_gains(plan[p]));
            if (p == 0)
                long_stall_req = 1'b1;
            if (p == $size(plan) - 1)
                quiet = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        // halt, then requests that must be ignored
        send_item(fresh(KIND_STATUS));
        send_item(fresh(KIND_NEW_DATA));
        send_item(fresh(KIND_STEP));
        send_item(fresh(KIND_STOP));
        send_item(fresh(KIND_DISARM));
        send_item(fresh(KIND_STATUS));
        drain();

        tracker.report_leftover();
        $display("%0d requests over %0d gain settings, %0d gain writes, %0d results checked",
                 tracker.requests, $size(plan) + 2, tracker.gain_writes, tracker.checked);
        if (tracker.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches", tracker.errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
